// ----- rtl/core/cda_pkg.sv -----
// Shared types, constants, microcode program and month table for the date/time adder.
package cda_pkg;

  localparam int YEAR_BITS    = 16;
  localparam int ADD_DAY_BITS = 12;
  localparam int DAY_W        = (ADD_DAY_BITS > 6) ? ADD_DAY_BITS + 1 : 7;
  localparam int SEC_W        = 7;
  localparam int MIN_W        = 7;
  localparam int HOUR_W       = 6;
  localparam int STEP_W       = 4;

  typedef logic [YEAR_BITS-1:0]    year_t;
  typedef logic [ADD_DAY_BITS-1:0] add_day_t;
  typedef logic [DAY_W-1:0]        day_t;
  typedef logic [SEC_W-1:0]        sec_t;
  typedef logic [MIN_W-1:0]        min_t;
  typedef logic [HOUR_W-1:0]       hour_t;
  typedef logic [STEP_W-1:0]       step_t;

  localparam sec_t  SEC_LIMIT   = SEC_W'(60);
  localparam min_t  MIN_LIMIT   = MIN_W'(60);
  localparam hour_t HOUR_LIMIT  = HOUR_W'(24);
  localparam logic [3:0] MONTHS = 4'd12;
  localparam logic [4:0] MAX_HOUR = 5'd23;
  localparam logic [5:0] MAX_MIN_SEC = 6'd59;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_NOP,
    OP_ADD_SEC,
    OP_NORM_SEC,
    OP_ADD_MIN,
    OP_NORM_MIN,
    OP_ADD_HOUR,
    OP_NORM_HOUR,
    OP_ADD_DAY,
    OP_NORM_DAY,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_NO_ACCEPT,
    JC_LOAD,
    JC_CARRY,
    JC_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic load_mode;
    logic carry;
    logic out_busy;
  } status_t;

  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_DISPATCH  = 4'd1;
  localparam step_t STEP_ADD_SEC   = 4'd2;
  localparam step_t STEP_NORM_SEC  = 4'd3;
  localparam step_t STEP_ADD_MIN   = 4'd4;
  localparam step_t STEP_NORM_MIN  = 4'd5;
  localparam step_t STEP_ADD_HOUR  = 4'd6;
  localparam step_t STEP_NORM_HOUR = 4'd7;
  localparam step_t STEP_ADD_DAY   = 4'd8;
  localparam step_t STEP_NORM_DAY  = 4'd9;
  localparam step_t STEP_EMIT      = 4'd10;
  localparam step_t STEP_RETURN    = 4'd11;

  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:      w = '{OP_ACCEPT,    JC_NO_ACCEPT, STEP_IDLE};
      STEP_DISPATCH:  w = '{OP_NOP,       JC_LOAD,      STEP_EMIT};
      STEP_ADD_SEC:   w = '{OP_ADD_SEC,   JC_NEXT,      STEP_IDLE};
      STEP_NORM_SEC:  w = '{OP_NORM_SEC,  JC_CARRY,     STEP_NORM_SEC};
      STEP_ADD_MIN:   w = '{OP_ADD_MIN,   JC_NEXT,      STEP_IDLE};
      STEP_NORM_MIN:  w = '{OP_NORM_MIN,  JC_CARRY,     STEP_NORM_MIN};
      STEP_ADD_HOUR:  w = '{OP_ADD_HOUR,  JC_NEXT,      STEP_IDLE};
      STEP_NORM_HOUR: w = '{OP_NORM_HOUR, JC_CARRY,     STEP_NORM_HOUR};
      STEP_ADD_DAY:   w = '{OP_ADD_DAY,   JC_NEXT,      STEP_IDLE};
      STEP_NORM_DAY:  w = '{OP_NORM_DAY,  JC_CARRY,     STEP_NORM_DAY};
      STEP_EMIT:      w = '{OP_EMIT,      JC_OUT_BUSY,  STEP_EMIT};
      STEP_RETURN:    w = '{OP_NOP,       JC_ALWAYS,    STEP_IDLE};
      default:        w = '{OP_NOP,       JC_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/cda_useq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module cda_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cda_pkg::status_t status_i,
  output cda_pkg::op_e     op_o
);
  import cda_pkg::*;

  step_t  upc_q, upc_d;
  uword_t uword;
  logic   take;

  always_comb begin
    uword = ucode_rom(upc_q);
    case (uword.cond)
      JC_NEXT:      take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NO_ACCEPT: take = !status_i.accept;
      JC_LOAD:      take = status_i.load_mode;
      JC_CARRY:     take = status_i.carry;
      JC_OUT_BUSY:  take = status_i.out_busy;
      default:      take = 1'b1;
    endcase
    upc_d = take ? uword.target : upc_q + step_t'(1);
    op_o  = uword.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- rtl/core/cda_dpath.sv -----
// Datapath: date and time registers, carry tests, handshakes and the output register.
module cda_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cda_pkg::op_e      op_i,
  output cda_pkg::status_t  status_o,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic              mode_i,
  input  logic [15:0]       load_year_i,
  input  logic [3:0]        load_month_i,
  input  logic [4:0]        load_day_i,
  input  logic [4:0]        load_hour_i,
  input  logic [5:0]        load_minute_i,
  input  logic [5:0]        load_second_i,
  input  logic [11:0]       add_days_i,
  input  logic [4:0]        add_hours_i,
  input  logic [5:0]        add_minutes_i,
  input  logic [5:0]        add_seconds_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [15:0]       out_year_o,
  output logic [3:0]        out_month_o,
  output logic [4:0]        out_day_o,
  output logic [4:0]        out_hour_o,
  output logic [5:0]        out_minute_o,
  output logic [5:0]        out_second_o
);
  import cda_pkg::*;

  year_t      year_q;
  logic [3:0] month_q;
  day_t       day_q;
  hour_t      hour_q;
  min_t       min_q;
  sec_t       sec_q;
  logic       mode_q;
  add_day_t   add_days_q;
  logic [4:0] add_hours_q;
  logic [5:0] add_min_q;
  logic [5:0] add_sec_q;
  logic       out_valid_q;
  logic [15:0] out_year_q;
  logic [3:0]  out_month_q;
  logic [4:0]  out_day_q;
  logic [4:0]  out_hour_q;
  logic [5:0]  out_min_q;
  logic [5:0]  out_sec_q;

  logic       accept;
  logic       out_busy;
  logic       emit;
  logic [4:0] cur_len;
  logic [3:0] ld_month;
  logic [4:0] ld_day;
  logic [4:0] ld_hour;
  logic [5:0] ld_min;
  logic [5:0] ld_sec;

  assign stall_o  = (op_i != OP_ACCEPT);
  assign accept   = valid_i && !stall_o;
  assign out_busy = out_valid_q && stall_i;
  assign emit     = (op_i == OP_EMIT) && !out_busy;
  assign cur_len  = month_len(month_q);

  always_comb begin
    ld_month = load_month_i;
    if (load_month_i == 4'd0) begin
      ld_month = 4'd1;
    end else if (load_month_i > MONTHS) begin
      ld_month = MONTHS;
    end
    ld_day  = (load_day_i == 5'd0) ? 5'd1 : load_day_i;
    ld_hour = (load_hour_i > MAX_HOUR) ? MAX_HOUR : load_hour_i;
    ld_min  = (load_minute_i > MAX_MIN_SEC) ? MAX_MIN_SEC : load_minute_i;
    ld_sec  = (load_second_i > MAX_MIN_SEC) ? MAX_MIN_SEC : load_second_i;
  end

  always_comb begin
    status_o.accept    = accept;
    status_o.load_mode = !mode_q;
    status_o.out_busy  = out_busy;
    case (op_i)
      OP_NORM_SEC:  status_o.carry = (sec_q >= SEC_LIMIT);
      OP_NORM_MIN:  status_o.carry = (min_q >= MIN_LIMIT);
      OP_NORM_HOUR: status_o.carry = (hour_q >= HOUR_LIMIT);
      OP_NORM_DAY:  status_o.carry = (day_q > day_t'(cur_len));
      default:      status_o.carry = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= '0;
      month_q     <= 4'd1;
      day_q       <= day_t'(1);
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_ACCEPT: begin
          if (accept) begin
            mode_q <= mode_i;
            if (!mode_i) begin
              year_q  <= year_t'(load_year_i);
              month_q <= ld_month;
              day_q   <= day_t'(ld_day);
              hour_q  <= hour_t'(ld_hour);
              min_q   <= min_t'(ld_min);
              sec_q   <= sec_t'(ld_sec);
            end
          end
        end
        OP_ADD_SEC: sec_q <= sec_q + sec_t'(add_sec_q);
        OP_NORM_SEC: begin
          if (sec_q >= SEC_LIMIT) begin
            sec_q <= sec_q - SEC_LIMIT;
            min_q <= min_q + min_t'(1);
          end
        end
        OP_ADD_MIN: min_q <= min_q + min_t'(add_min_q);
        OP_NORM_MIN: begin
          if (min_q >= MIN_LIMIT) begin
            min_q  <= min_q - MIN_LIMIT;
            hour_q <= hour_q + hour_t'(1);
          end
        end
        OP_ADD_HOUR: hour_q <= hour_q + hour_t'(add_hours_q);
        OP_NORM_HOUR: begin
          if (hour_q >= HOUR_LIMIT) begin
            hour_q <= hour_q - HOUR_LIMIT;
            day_q  <= day_q + day_t'(1);
          end
        end
        OP_ADD_DAY: day_q <= day_q + day_t'(add_days_q);
        OP_NORM_DAY: begin
          if (day_q > day_t'(cur_len)) begin
            day_q <= day_q - day_t'(cur_len);
            if (month_q >= MONTHS) begin
              month_q <= 4'd1;
              year_q  <= year_q + year_t'(1);
            end else begin
              month_q <= month_q + 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      add_days_q  <= add_day_t'(add_days_i);
      add_hours_q <= add_hours_i;
      add_min_q   <= add_minutes_i;
      add_sec_q   <= add_seconds_i;
    end
    if (emit) begin
      out_year_q  <= 16'(year_q);
      out_month_q <= month_q;
      out_day_q   <= day_q[4:0];
      out_hour_q  <= hour_q[4:0];
      out_min_q   <= min_q[5:0];
      out_sec_q   <= sec_q[5:0];
    end
  end

  assign valid_o      = out_valid_q;
  assign out_year_o   = out_year_q;
  assign out_month_o  = out_month_q;
  assign out_day_o    = out_day_q;
  assign out_hour_o   = out_hour_q;
  assign out_minute_o = out_min_q;
  assign out_second_o = out_sec_q;

endmodule

// ----- rtl/core/calendar_datetime_adder.sv -----
// Top level of the calendar date and time adder.
// A load word goes from idle via dispatch to emit, which fills the output register.
// An add word runs the add and normalise steps for seconds, minutes, hours and days,
// with one more normalise step per time carry and per month rolled; for 4095 days
// the month roll loop sets the run. From emit, return leads to idle for a new word.
// Reset (asynchronous, active low) sets 0000-01-01 00:00:00 and empties the output.
module calendar_datetime_adder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        mode_i,
  input  logic [15:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  logic [4:0]  load_hour_i,
  input  logic [5:0]  load_minute_i,
  input  logic [5:0]  load_second_i,
  input  logic [11:0] add_days_i,
  input  logic [4:0]  add_hours_i,
  input  logic [5:0]  add_minutes_i,
  input  logic [5:0]  add_seconds_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o
);
  import cda_pkg::*;

  op_e     op;
  status_t status;

  cda_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  cda_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .mode_i        (mode_i),
    .load_year_i   (load_year_i),
    .load_month_i  (load_month_i),
    .load_day_i    (load_day_i),
    .load_hour_i   (load_hour_i),
    .load_minute_i (load_minute_i),
    .load_second_i (load_second_i),
    .add_days_i    (add_days_i),
    .add_hours_i   (add_hours_i),
    .add_minutes_i (add_minutes_i),
    .add_seconds_i (add_seconds_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .out_year_o    (out_year_o),
    .out_month_o   (out_month_o),
    .out_day_o     (out_day_o),
    .out_hour_o    (out_hour_o),
    .out_minute_o  (out_minute_o),
    .out_second_o  (out_second_o)
  );

endmodule

// ----- rtl/core/cda_checker.sv -----
// Port-level checks for the calendar date and time adder, bound to the top level.
module cda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [15:0] out_year_o,
  input logic [3:0]  out_month_o,
  input logic [4:0]  out_day_o,
  input logic [4:0]  out_hour_o,
  input logic [5:0]  out_minute_o,
  input logic [5:0]  out_second_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_year_o) && $stable(out_month_o)
      && $stable(out_day_o) && $stable(out_hour_o) && $stable(out_minute_o)
      && $stable(out_second_o))
    else $error("Stalled result word changed.");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_month_o >= 4'd1 && out_month_o <= 4'd12)
    else $error("Result month out of range.");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_hour_o <= 5'd23 && out_minute_o <= 6'd59 && out_second_o <= 6'd59)
    else $error("Result time out of range.");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_day_o != 5'd0)
    else $error("Result day is zero.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("Second word taken while one is in progress.");

endmodule

bind calendar_datetime_adder cda_checker u_cda_checker (.*);
